### sv/hcm_pkg.sv
// hcm_pkg: shared types, constants and the color ramp for the heat-map color mapper
// used by hcm_channel and heatmap_color_mapper; no dependencies
package hcm_pkg;

   localparam int SampleW = 16;
   localparam int CsrW    = 32;
   localparam int ColorW  = 8;
   localparam int LevelW  = 7;
   localparam int FracW   = 17;
   localparam int SegW    = 3;
   localparam int ProdW   = 23;
   localparam int NumW    = 31;
   localparam int QuotW   = 15;
   localparam int RecipW  = 16;
   localparam int Stages  = 6;

   localparam logic signed [CsrW-1:0] GainReset   = 32'sh0001_0000;
   localparam logic signed [CsrW-1:0] OffsetReset = 32'sh0000_0000;

   localparam logic [FracW-1:0] FracOne  = 17'h1_0000;
   localparam logic [SegW-1:0]  SegLast  = 3'd4;
   localparam logic [NumW-1:0]  RoundHalf = 31'd3276800;
   localparam logic [RecipW-1:0] Recip100 = 16'd41944;

   typedef enum logic [0:0] {
      CSR_GAIN   = 1'b0,
      CSR_OFFSET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LevelW-1:0] red;
      logic [LevelW-1:0] green;
      logic [LevelW-1:0] blue;
   } rgb_level_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic out_en;
   } pipe_en_type;

   // control colors in hundredths of full scale
   function automatic rgb_level_type ramp_color(input logic [SegW-1:0] point);
      rgb_level_type c;
      unique case (point)
         3'd0:    c = '{red: 7'd0,   green: 7'd0,   blue: 7'd65};
         3'd1:    c = '{red: 7'd0,   green: 7'd35,  blue: 7'd100};
         3'd2:    c = '{red: 7'd15,  green: 7'd100, blue: 7'd95};
         3'd3:    c = '{red: 7'd95,  green: 7'd100, blue: 7'd15};
         3'd4:    c = '{red: 7'd100, green: 7'd35,  blue: 7'd0};
         3'd5:    c = '{red: 7'd65,  green: 7'd0,   blue: 7'd0};
         default: c = '{red: 7'd0,   green: 7'd0,   blue: 7'd0};
      endcase
      return c;
   endfunction

endpackage

### sv/heatmap_color_mapper.sv
// heatmap_color_mapper: top level, sample scaling, clamp and segment stages
// depends on hcm_pkg and hcm_channel
//
// Usage:
//   req channel carries one signed 16-bit sample per item, rsp channel one
//   8-bit red, green and blue per item; an item moves when valid is high and
//   stall is low. csr_wr_en writes gain (index 0, signed Q16.16) or offset
//   (index 1, signed Q16.16); write them only while no item is in flight.
//   Pipeline is six register stages: multiply, offset and clamp, segment
//   split, blend products, scale and round, divide by 100. A result shows on
//   rsp_valid after its item has passed every stage. One item per cycle is
//   sustained unless rsp_stall holds it; the six-stage pipeline has no loops.
//   When rsp_stall is high and the last stage is full, stages close up their
//   bubbles and then hold; req_stall rises only when every stage is full.
//   Nothing is lost or repeated across a stall.
//   Reset empties the pipeline and sets gain to 1.0 and offset to 0.
module heatmap_color_mapper (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [hcm_pkg::SampleW-1:0] req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hcm_pkg::ColorW-1:0]         rsp_red,
   output logic [hcm_pkg::ColorW-1:0]         rsp_green,
   output logic [hcm_pkg::ColorW-1:0]         rsp_blue,
   input  logic                               csr_wr_en,
   input  hcm_pkg::csr_index_type             csr_index,
   input  logic [hcm_pkg::CsrW-1:0]           csr_wdata
);

   logic signed [hcm_pkg::CsrW-1:0]        gain_ff;
   logic signed [hcm_pkg::CsrW-1:0]        offset_ff;
   logic [hcm_pkg::Stages-1:0]             vld_ff;
   logic [hcm_pkg::Stages-1:0]             vld_in;
   logic [hcm_pkg::Stages-1:0]             adv;

   logic signed [47:0]                     prod_in;
   logic signed [47:0]                     prod_ff;
   logic signed [48:0]                     acc;
   logic [hcm_pkg::FracW-1:0]              v_in;
   logic [hcm_pkg::FracW-1:0]              v_ff;
   logic [18:0]                            t5;
   logic [18:0]                            t5_rem;
   logic [hcm_pkg::SegW-1:0]               seg_in;
   logic [hcm_pkg::SegW-1:0]               seg_ff;
   logic [hcm_pkg::FracW-1:0]              frac_in;
   logic [hcm_pkg::FracW-1:0]              frac_ff;
   hcm_pkg::rgb_level_type                 lo;
   hcm_pkg::rgb_level_type                 hi;
   hcm_pkg::pipe_en_type                   pipe_en;

   // csr
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= hcm_pkg::GainReset;
         offset_ff <= hcm_pkg::OffsetReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hcm_pkg::CSR_GAIN:   gain_ff   <= csr_wdata;
            hcm_pkg::CSR_OFFSET: offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage advance, last stage first
   always_comb begin
      adv[hcm_pkg::Stages-1] = !vld_ff[hcm_pkg::Stages-1] || !rsp_stall;
      for (int k = hcm_pkg::Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      vld_in = vld_ff;
      if (adv[0]) begin
         vld_in[0] = req_valid;
      end
      for (int k = 1; k < hcm_pkg::Stages; k++) begin
         if (adv[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[hcm_pkg::Stages-1];

   // stage 1: scale
   assign prod_in = req_sample * gain_ff;

   // stage 2: offset and clamp to [0, 1]
   assign acc = {prod_ff[47], prod_ff} + {{17{offset_ff[hcm_pkg::CsrW-1]}}, offset_ff};

   always_comb begin
      priority if (acc[48]) begin
         v_in = '0;
      end else if (acc[47:0] > {31'b0, hcm_pkg::FracOne}) begin
         v_in = hcm_pkg::FracOne;
      end else begin
         v_in = acc[hcm_pkg::FracW-1:0];
      end
   end

   // stage 3: times five, split into segment and fraction
   assign t5      = {2'b0, v_ff} + {v_ff, 2'b0};
   assign seg_in  = (t5[18:16] > hcm_pkg::SegLast) ? hcm_pkg::SegLast : t5[18:16];
   assign t5_rem  = t5 - {seg_in, 16'b0};
   assign frac_in = t5_rem[hcm_pkg::FracW-1:0];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         prod_ff <= prod_in;
      end
      if (adv[1]) begin
         v_ff <= v_in;
      end
      if (adv[2]) begin
         seg_ff  <= seg_in;
         frac_ff <= frac_in;
      end
   end

   // stages 4 to 6 per channel
   assign lo = hcm_pkg::ramp_color(seg_ff);
   assign hi = hcm_pkg::ramp_color(seg_ff + 3'd1);

   assign pipe_en.mul_en = adv[3];
   assign pipe_en.sum_en = adv[4];
   assign pipe_en.out_en = adv[5];

   hcm_channel u_red (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .level_lo (lo.red),
      .level_hi (hi.red),
      .frac     (frac_ff),
      .level    (rsp_red)
   );

   hcm_channel u_green (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .level_lo (lo.green),
      .level_hi (hi.green),
      .frac     (frac_ff),
      .level    (rsp_green)
   );

   hcm_channel u_blue (
      .clock    (clock),
      .pipe_en  (pipe_en),
      .level_lo (lo.blue),
      .level_hi (hi.blue),
      .frac     (frac_ff),
      .level    (rsp_blue)
   );

`ifndef SYNTHESIS
   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> v_ff <= hcm_pkg::FracOne)
      else $error("clamped value above one");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> seg_ff <= hcm_pkg::SegLast)
      else $error("segment index above last");

   a_frac_full: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && frac_ff[hcm_pkg::FracW-1]) |->
         (seg_ff == hcm_pkg::SegLast && frac_ff == hcm_pkg::FracOne))
      else $error("full fraction outside last segment");

   a_no_input_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && req_stall) |=> vld_ff[0] && $stable(prod_ff))
      else $error("first stage changed while stalled");
`endif

endmodule

### sv/hcm_channel.sv
// hcm_channel: one color channel, last three pipeline stages (blend products, scale and round, divide by 100)
// depends on hcm_pkg
module hcm_channel (
   input  logic                           clock,
   input  hcm_pkg::pipe_en_type           pipe_en,
   input  logic [hcm_pkg::LevelW-1:0]     level_lo,
   input  logic [hcm_pkg::LevelW-1:0]     level_hi,
   input  logic [hcm_pkg::FracW-1:0]      frac,
   output logic [hcm_pkg::ColorW-1:0]     level
);

   logic [hcm_pkg::FracW-1:0]              inv;
   logic [hcm_pkg::ProdW:0]                p0_full;
   logic [hcm_pkg::ProdW:0]                p1_full;
   logic [hcm_pkg::ProdW-1:0]              p0_ff;
   logic [hcm_pkg::ProdW-1:0]              p1_ff;
   logic [hcm_pkg::ProdW-1:0]              sum;
   logic [hcm_pkg::NumW-1:0]               num;
   logic [hcm_pkg::QuotW-1:0]              y_in;
   logic [hcm_pkg::QuotW-1:0]              y_ff;
   logic [hcm_pkg::NumW-1:0]               q_full;
   logic [hcm_pkg::ColorW-1:0]             level_in;
   logic [hcm_pkg::ColorW-1:0]             level_ff;

   // blend weights
   assign inv     = hcm_pkg::FracOne - frac;
   assign p0_full = level_lo * inv;
   assign p1_full = level_hi * frac;

   // 255 * sum + half of 100 * 2^16, then drop the 2^16
   assign sum  = p0_ff + p1_ff;
   assign num  = ({sum, 8'b0} - {8'b0, sum}) + hcm_pkg::RoundHalf;
   assign y_in = num[hcm_pkg::NumW-1:16];

   // divide by 100 with a reciprocal
   assign q_full   = y_ff * hcm_pkg::Recip100;
   assign level_in = q_full[29:22];

   always_ff @(posedge clock) begin
      if (pipe_en.mul_en) begin
         p0_ff <= p0_full[hcm_pkg::ProdW-1:0];
         p1_ff <= p1_full[hcm_pkg::ProdW-1:0];
      end
      if (pipe_en.sum_en) begin
         y_ff <= y_in;
      end
      if (pipe_en.out_en) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### test/heatmap_color_mapper_tb.sv
// heatmap_color_mapper_tb: self-checking testbench for the heat-map color mapper
// predicts each rgb item from the sample, gain and offset and checks it in order
// depends on hcm_pkg and heatmap_color_mapper
module heatmap_color_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned UnitQ16   = 65536;
   localparam longint unsigned FullDen   = 6553600;
   localparam longint unsigned RoundBias = 3276800;

   typedef logic signed [hcm_pkg::SampleW-1:0] sample_type;
   typedef logic [hcm_pkg::ColorW-1:0]         level_type;

   typedef struct packed {
      level_type red;
      level_type green;
      level_type blue;
   } color_type;

   typedef struct packed {
      sample_type  sample;
      logic [2:0]  gap;
   } sample_slot_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   sample_type                      req_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   level_type                       rsp_red;
   level_type                       rsp_green;
   level_type                       rsp_blue;
   logic                            csr_wr_en = 1'b0;
   hcm_pkg::csr_index_type          csr_index = hcm_pkg::CSR_GAIN;
   logic [hcm_pkg::CsrW-1:0]        csr_wdata = '0;

   logic signed [hcm_pkg::CsrW-1:0] gain_q = hcm_pkg::GainReset;
   logic signed [hcm_pkg::CsrW-1:0] offset_q = hcm_pkg::OffsetReset;

   sample_slot_type samples_waiting[$];
   color_type       colors_due[$];
   logic            req_taken = 1'b0;
   logic            rsp_taken = 1'b0;
   logic            no_idle = 1'b0;
   int              gap_left = -1;
   int              stall_left = 0;
   int              items_queued = 0;
   int              results_seen = 0;
   int              mismatches = 0;
   int              settings_used = 1;

   heatmap_color_mapper dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_sample(req_sample),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // control colors in hundredths
   function automatic color_type ramp_point(int unsigned pt);
      color_type c;
      case (pt)
         0:       c = {8'd0,   8'd0,   8'd65};
         1:       c = {8'd0,   8'd35,  8'd100};
         2:       c = {8'd15,  8'd100, 8'd95};
         3:       c = {8'd95,  8'd100, 8'd15};
         4:       c = {8'd100, 8'd35,  8'd0};
         default: c = {8'd65,  8'd0,   8'd0};
      endcase
      return c;
   endfunction

   function automatic level_type mix_level(longint unsigned lo, longint unsigned hi,
                                           longint unsigned frac);
      longint unsigned num;
      num = 64'd255 * (lo * (UnitQ16 - frac) + hi * frac);
      return level_type'((num + RoundBias) / FullDen);
   endfunction

   function automatic color_type predict_color(sample_type s);
      longint          acc;
      longint unsigned lvl;
      longint unsigned t;
      longint unsigned seg;
      longint unsigned frac;
      color_type       lo;
      color_type       hi;
      color_type       c;
      acc = longint'(s) * longint'(gain_q) + longint'(offset_q);
      if (acc < 0) begin
         lvl = 0;
      end else if (acc > longint'(UnitQ16)) begin
         lvl = UnitQ16;
      end else begin
         lvl = longint'(acc);
      end
      t = 5 * lvl;
      seg = t >> 16;
      if (seg > 4) begin
         seg = 4;
      end
      frac = t - (seg << 16);
      lo = ramp_point(int'(seg));
      hi = ramp_point(int'(seg) + 1);
      c.red = mix_level(lo.red, hi.red, frac);
      c.green = mix_level(lo.green, hi.green, frac);
      c.blue = mix_level(lo.blue, hi.blue, frac);
      return c;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // sample driver
   always @(negedge clock) begin
      logic            next_valid;
      sample_slot_type slot;
      next_valid = req_valid && !req_taken;
      if (!reset && !next_valid && samples_waiting.size() != 0) begin
         if (gap_left < 0) begin
            gap_left = samples_waiting[0].gap;
         end
         if (gap_left == 0) begin
            slot = samples_waiting.pop_front();
            req_sample <= slot.sample;
            next_valid = 1'b1;
            gap_left = -1;
         end else begin
            gap_left--;
         end
      end
      req_valid <= next_valid;
   end

   // color receiver back-pressure
   always @(negedge clock) begin
      if (rsp_taken) begin
         stall_left = no_idle ? 0 : $urandom_range(0, 6);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) begin
         stall_left--;
      end
   end

   // monitor
   always @(posedge clock) begin
      color_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (req_valid && !req_stall) begin
            colors_due.push_back(predict_color(req_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (colors_due.size() == 0) begin
               $error("unexpected color item: red %0d green %0d blue %0d",
                      rsp_red, rsp_green, rsp_blue);
               mismatches++;
            end else begin
               want = colors_due.pop_front();
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_red);
                  mismatches++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_green);
                  mismatches++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic queue_sample(input sample_type s);
      sample_slot_type slot;
      slot.sample = s;
      slot.gap = no_idle ? 3'd0 : 3'($urandom_range(0, 6));
      samples_waiting.push_back(slot);
      items_queued++;
   endtask

   task automatic drain();
      while (results_seen != items_queued) begin
         @(negedge clock);
      end
   endtask

   // both writes happen with the pipeline empty
   task automatic set_scale(input logic [hcm_pkg::CsrW-1:0] g,
                            input logic [hcm_pkg::CsrW-1:0] o);
      gain_q = g;
      offset_q = o;
      settings_used++;
      csr_wr_en <= 1'b1;
      csr_index <= hcm_pkg::CSR_GAIN;
      csr_wdata <= g;
      @(negedge clock);
      csr_index <= hcm_pkg::CSR_OFFSET;
      csr_wdata <= o;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int g;
      int o;
      int aim;
      int raw;
      int kind;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset scaling: zero, exactly one, below zero, above one
      queue_sample(16'sd0);
      queue_sample(16'sd1);
      queue_sample(-16'sd1);
      queue_sample(16'sd2);
      queue_sample(16'sd32767);
      queue_sample(-16'sd32768);
      drain();

      // segment boundaries
      set_scale(32'd2, 32'd0);
      queue_sample(16'sd6553);
      queue_sample(16'sd6554);
      queue_sample(16'sd3277);
      queue_sample(16'sd13107);
      queue_sample(16'sd19660);
      queue_sample(16'sd26214);
      queue_sample(16'sd32767);
      queue_sample(-16'sd5);
      drain();

      set_scale(32'd1, 32'd32768);
      queue_sample(-16'sd32768);
      queue_sample(16'sd32767);
      queue_sample(16'sd0);
      queue_sample(-16'sd1);
      drain();

      set_scale(32'h8000_0000, 32'h7FFF_FFFF);
      queue_sample(-16'sd32768);
      queue_sample(16'sd32767);
      queue_sample(16'sd0);
      queue_sample(16'sd1);
      drain();

      set_scale(32'h7FFF_FFFF, 32'h8000_0000);
      queue_sample(16'sd32767);
      queue_sample(-16'sd32768);
      queue_sample(16'sd0);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         no_idle = (ph % 4 == 3);
         kind = ph % 3;
         if (kind == 1) begin
            g = int'($urandom());
            o = int'($urandom());
         end else begin
            g = (kind == 0) ? $urandom_range(1, 4) : $urandom_range(1, 2);
            if ($urandom_range(0, 1) == 1) begin
               g = -g;
            end
            o = (kind == 0) ? $urandom_range(0, 131072) - 32768
                            : $urandom_range(0, 196608) - 65536;
         end
         set_scale(g, o);
         for (int n = 0; n < 50; n++) begin
            if (kind != 1 && $urandom_range(0, 3) != 0) begin
               // aim at a level inside the ramp
               aim = $urandom_range(0, 65536);
               raw = (aim - o) / g;
               if (raw > 32767) begin
                  raw = 32767;
               end else if (raw < -32768) begin
                  raw = -32768;
               end
               queue_sample(sample_type'(raw));
            end else begin
               queue_sample(sample_type'($urandom_range(0, 65535)));
            end
         end
         drain();
      end
      no_idle = 1'b0;

      drain();
      repeat (12) @(posedge clock);
      $display("checked %0d colors from %0d samples", results_seen, items_queued);
      $display("over %0d gain and offset settings with random gaps and stalls",
               settings_used);
      if (mismatches == 0 && colors_due.size() == 0) begin
         $display("heatmap_color_mapper regression: pass");
      end else begin
         $display("heatmap_color_mapper regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("heatmap_color_mapper regression: fail");
      $finish;
   end

endmodule
